### sv/wtp_pkg.sv
// Shared types, codes and helpers for the descriptor TLV parser.
// No dependencies; every other file of the block imports this package.
package wtp_pkg;

  typedef enum logic [2:0] {
    PH_FIXED = 3'd0,
    PH_SKIP  = 3'd1,
    PH_HDR   = 3'd2,
    PH_PAY   = 3'd3,
    PH_DRAIN = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_MAX_RAD = 3'd1,
    KIND_USE_RAD = 3'd2,
    KIND_HEADER  = 3'd3,
    KIND_PAYLOAD = 3'd4
  } field_kind_e;

  typedef enum logic [1:0] {
    VER_HARDWARE   = 2'd0,
    VER_SOFTWARE   = 2'd1,
    VER_BOOTLOADER = 2'd2,
    VER_UNKNOWN    = 2'd3
  } version_kind_e;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_ZERO_ENC  = 2'd1,
    FLT_TRUNC_HDR = 2'd2,
    FLT_OVERRUN   = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    CFG_STRICT_MODE = 3'd0,
    CFG_ALT_LAYOUT  = 3'd1,
    CFG_HW_TYPE     = 3'd2,
    CFG_SW_TYPE     = 3'd3,
    CFG_BOOT_TYPE   = 3'd4
  } cfg_index_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CountWidth    = 10;

  localparam logic [15:0] HwTypeReset   = 16'd0;
  localparam logic [15:0] SwTypeReset   = 16'd1;
  localparam logic [15:0] BootTypeReset = 16'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    field_kind_e   field_kind;
    logic [31:0]   field_value;
    version_kind_e version_kind;
    logic [15:0]   sub_length;
    logic          sub_end;
    logic          element_done;
    logic          element_ok;
    fault_e        fault;
  } out_t;

  typedef struct packed {
    logic        strict_mode;
    logic        alternate_layout;
    logic [15:0] hardware_type_code;
    logic [15:0] software_type_code;
    logic [15:0] bootloader_type_code;
  } cfg_t;

  function automatic version_kind_e classify(input logic [15:0] t, input cfg_t cfg);
    version_kind_e vk;
    priority if (t == cfg.hardware_type_code) vk = VER_HARDWARE;
    else if (t == cfg.software_type_code)     vk = VER_SOFTWARE;
    else if (t == cfg.bootloader_type_code)   vk = VER_BOOTLOADER;
    else                                      vk = VER_UNKNOWN;
    return vk;
  endfunction

endpackage

### sv/wtp_descriptor_tlv_parser_unit.sv
// Top level of the descriptor TLV parser: input register, parse core,
// result register and configuration registers. Uses wtp_pkg.
//
//   channel   direction  handshake                  word
//   in        input      in_valid_i / in_stall_o    wtp_pkg::in_t   in_data_i
//   out       output     out_valid_o / out_stall_i  wtp_pkg::out_t  out_data_o
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_stall_i is low; every input word yields one result word.
// Each word passes through the input register, then the parse logic into the result register.
// Reset clears the parse state and loads register defaults; cfg_ready_o stays high.
// A stalled result holds; the input register still takes one more word behind it.
module wtp_descriptor_tlv_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wtp_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wtp_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wtp_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [wtp_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import wtp_pkg::*;

  logic in_valid_q, in_valid_d;
  in_t  in_word_q;
  logic res_valid_q, res_valid_d;
  out_t res_word_q;
  out_t res_next;
  cfg_t cfg;
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    res_valid_d = res_valid_q;
    if (advance)           res_valid_d = 1'b1;
    else if (!out_stall_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_word_q <= in_data_i;
    if (advance) res_word_q <= res_next;
  end

  wtp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wtp_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .word_i (in_word_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_word_q;

endmodule

### sv/wtp_cfg_regs.sv
// Configuration register file of the descriptor TLV parser.
// Depends on wtp_pkg for the register index codes and the cfg_t bundle.
module wtp_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wtp_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [wtp_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output wtp_pkg::cfg_t                       cfg_o
);
  import wtp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_STRICT_MODE: cfg_d.strict_mode          = cfg_data_i[0];
        CFG_ALT_LAYOUT:  cfg_d.alternate_layout     = cfg_data_i[0];
        CFG_HW_TYPE:     cfg_d.hardware_type_code   = cfg_data_i;
        CFG_SW_TYPE:     cfg_d.software_type_code   = cfg_data_i;
        CFG_BOOT_TYPE:   cfg_d.bootloader_type_code = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strict_mode          <= 1'b0;
      cfg_q.alternate_layout     <= 1'b0;
      cfg_q.hardware_type_code   <= HwTypeReset;
      cfg_q.software_type_code   <= SwTypeReset;
      cfg_q.bootloader_type_code <= BootTypeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/wtp_parse_core.sv
// Parse state machine: phase, counters and collected header words,
// plus the combinational result for the word being stepped. Uses wtp_pkg.
module wtp_parse_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  wtp_pkg::in_t  word_i,
  input  wtp_pkg::cfg_t cfg_i,
  output wtp_pkg::out_t res_o
);
  import wtp_pkg::*;

  phase_e                phase_q, phase_d, phase_n;
  logic [CountWidth-1:0] count_q, count_d, count_n;
  logic [31:0]           vendor_q, vendor_d, vendor_n;
  logic [15:0]           type_q, type_d, type_n;
  logic [15:0]           length_q, length_d, length_n;
  logic [15:0]           left_q, left_d, left_n;
  fault_e                fault_q, fault_d, fault_s, fault_n;
  logic [2:0]            hdr_idx;
  logic [7:0]            b;

  assign b       = word_i.data_byte;
  assign hdr_idx = count_q[2:0];

  // next state
  always_comb begin
    phase_n  = phase_q;
    count_n  = count_q;
    vendor_n = vendor_q;
    type_n   = type_q;
    length_n = length_q;
    left_n   = left_q;
    fault_s  = fault_q;
    unique case (phase_q)
      PH_FIXED: begin
        if (count_q == CountWidth'(0)) begin
          count_n = CountWidth'(1);
        end else if (count_q == CountWidth'(1)) begin
          count_n = CountWidth'(2);
        end else if (count_q == CountWidth'(2)) begin
          if (cfg_i.alternate_layout) begin
            count_n = CountWidth'(3);
          end else if (b == 8'd0) begin
            if (cfg_i.strict_mode) begin
              fault_s = FLT_ZERO_ENC;
              phase_n = PH_DRAIN;
            end else begin
              phase_n = PH_HDR;
            end
            count_n = '0;
          end else begin
            phase_n = PH_SKIP;
            count_n = {2'b00, b} + {1'b0, b, 1'b0};
          end
        end else begin
          phase_n = PH_HDR;
          count_n = '0;
        end
      end
      PH_SKIP: begin
        count_n = count_q - CountWidth'(1);
        if (count_n == CountWidth'(0)) phase_n = PH_HDR;
      end
      PH_HDR: begin
        if (hdr_idx < 3'd4)      vendor_n = {vendor_q[23:0], b};
        else if (hdr_idx < 3'd6) type_n   = {type_q[7:0], b};
        else                     length_n = {length_q[7:0], b};
        if (hdr_idx == 3'd7) begin
          count_n = '0;
          if (length_n != 16'd0) begin
            left_n  = length_n;
            phase_n = PH_PAY;
          end
        end else begin
          count_n = CountWidth'(hdr_idx + 3'd1);
        end
      end
      PH_PAY: begin
        left_n = left_q - 16'd1;
        if (left_n == 16'd0) begin
          phase_n = PH_HDR;
          count_n = '0;
        end
      end
      PH_DRAIN: ;
      default: ;
    endcase

    fault_n = fault_s;
    if (word_i.last && fault_s == FLT_NONE) begin
      priority if (phase_n == PH_HDR && count_n == CountWidth'(0)) fault_n = FLT_NONE;
      else if (phase_n == PH_PAY)                                  fault_n = FLT_OVERRUN;
      else                                                         fault_n = FLT_TRUNC_HDR;
    end

    if (word_i.last) begin
      phase_d  = PH_FIXED;
      count_d  = '0;
      vendor_d = '0;
      type_d   = '0;
      length_d = '0;
      left_d   = '0;
      fault_d  = FLT_NONE;
    end else begin
      phase_d  = phase_n;
      count_d  = count_n;
      vendor_d = vendor_n;
      type_d   = type_n;
      length_d = length_n;
      left_d   = left_n;
      fault_d  = fault_n;
    end
  end

  // outputs
  always_comb begin
    res_o              = '0;
    res_o.field_kind   = KIND_NONE;
    res_o.version_kind = VER_HARDWARE;
    unique case (phase_q)
      PH_FIXED: begin
        if (count_q == CountWidth'(0)) begin
          res_o.field_kind  = KIND_MAX_RAD;
          res_o.field_value = {24'd0, b};
        end else if (count_q == CountWidth'(1)) begin
          res_o.field_kind  = KIND_USE_RAD;
          res_o.field_value = {24'd0, b};
        end
      end
      PH_HDR: begin
        if (hdr_idx == 3'd7) begin
          res_o.field_kind   = KIND_HEADER;
          res_o.field_value  = vendor_n;
          res_o.version_kind = classify(type_n, cfg_i);
          res_o.sub_length   = length_n;
          res_o.sub_end      = (length_n == 16'd0);
        end
      end
      PH_PAY: begin
        res_o.field_kind   = KIND_PAYLOAD;
        res_o.field_value  = {24'd0, b};
        res_o.version_kind = classify(type_q, cfg_i);
        res_o.sub_length   = length_q;
        res_o.sub_end      = (left_n == 16'd0);
      end
      PH_SKIP, PH_DRAIN: ;
      default: ;
    endcase
    res_o.element_done = word_i.last;
    res_o.element_ok   = word_i.last && (fault_s == FLT_NONE) && (phase_n == PH_HDR)
                         && (count_n == CountWidth'(0));
    res_o.fault        = fault_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIXED;
      count_q  <= '0;
      vendor_q <= '0;
      type_q   <= '0;
      length_q <= '0;
      left_q   <= '0;
      fault_q  <= FLT_NONE;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      vendor_q <= vendor_d;
      type_q   <= type_d;
      length_q <= length_d;
      left_q   <= left_d;
      fault_q  <= fault_d;
    end
  end

endmodule

### sv/wtp_checker.sv
// Port-level checks for the descriptor TLV parser top level, bound in below.
// Uses wtp_pkg for the result word type and codes.
module wtp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input wtp_pkg::out_t out_data_o
);
  import wtp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.element_ok |->
      out_data_o.element_done && out_data_o.fault == FLT_NONE)
    else $error("element accepted without done or with a fault");

  a_sub_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.field_kind != KIND_HEADER
      && out_data_o.field_kind != KIND_PAYLOAD |->
      out_data_o.sub_length == 16'd0 && out_data_o.version_kind == VER_HARDWARE
      && !out_data_o.sub_end)
    else $error("sub-element fields set outside a sub-element");

endmodule

bind wtp_descriptor_tlv_parser_unit wtp_checker u_wtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### verif/tb_wtp_descriptor_tlv_parser_unit.sv
// Self-checking bench for wtp_descriptor_tlv_parser_unit: descriptor elements byte by byte,
// each result word checked against a built-in parser model under changing register settings.
// Depends on wtp_pkg and the parser RTL.
module tb_wtp_descriptor_tlv_parser_unit;
  import wtp_pkg::*;

  typedef logic [7:0] octets_t[$];

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned PhaseBytes  = 150;
  localparam int unsigned ShowLimit   = 10;
  localparam int unsigned RandomBytes = 1150;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  in_t                      in_data = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_t                     out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  cfg_t        cfg;
  phase_e      ph;
  logic [9:0]  cnt;
  logic [31:0] vend;
  logic [15:0] typ;
  logic [15:0] len;
  logic [15:0] left;
  fault_e      held;

  out_t        parse_results_q[$];
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 25;

  wtp_descriptor_tlv_parser_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_parse();
    ph   = PH_FIXED;
    cnt  = '0;
    vend = '0;
    typ  = '0;
    len  = '0;
    left = '0;
    held = FLT_NONE;
  endfunction

  function automatic version_kind_e type_version(input logic [15:0] t);
    if (t == cfg.hardware_type_code) return VER_HARDWARE;
    if (t == cfg.software_type_code) return VER_SOFTWARE;
    if (t == cfg.bootloader_type_code) return VER_BOOTLOADER;
    return VER_UNKNOWN;
  endfunction

  function automatic out_t parse_step(input in_t w);
    out_t r;
    int unsigned hc;
    r = '0;
    case (ph)
      PH_FIXED: begin
        if (cnt == 10'd0) begin
          r.field_kind  = KIND_MAX_RAD;
          r.field_value = 32'(w.data_byte);
          cnt = 10'd1;
        end else if (cnt == 10'd1) begin
          r.field_kind  = KIND_USE_RAD;
          r.field_value = 32'(w.data_byte);
          cnt = 10'd2;
        end else if (cnt == 10'd2) begin
          if (cfg.alternate_layout) begin
            cnt = 10'd3;
          end else if (w.data_byte == 8'd0) begin
            if (cfg.strict_mode) begin
              held = FLT_ZERO_ENC;
              ph   = PH_DRAIN;
            end else begin
              ph = PH_HDR;
            end
            cnt = '0;
          end else begin
            ph  = PH_SKIP;
            cnt = 10'(w.data_byte) * 10'd3;
          end
        end else begin
          ph  = PH_HDR;
          cnt = '0;
        end
      end
      PH_SKIP: begin
        cnt = cnt - 10'd1;
        if (cnt == 10'd0) ph = PH_HDR;
      end
      PH_HDR: begin
        hc = cnt[2:0];
        if (hc < 4) vend = {vend[23:0], w.data_byte};
        else if (hc < 6) typ = {typ[7:0], w.data_byte};
        else len = {len[7:0], w.data_byte};
        hc++;
        if (hc == 8) begin
          r.field_kind   = KIND_HEADER;
          r.field_value  = vend;
          r.version_kind = type_version(typ);
          r.sub_length   = len;
          cnt = '0;
          if (len == 16'd0) begin
            r.sub_end = 1'b1;
          end else begin
            left = len;
            ph   = PH_PAY;
          end
        end else begin
          cnt = 10'(hc);
        end
      end
      PH_PAY: begin
        r.field_kind   = KIND_PAYLOAD;
        r.field_value  = 32'(w.data_byte);
        r.version_kind = type_version(typ);
        r.sub_length   = len;
        left = left - 16'd1;
        if (left == 16'd0) begin
          r.sub_end = 1'b1;
          ph  = PH_HDR;
          cnt = '0;
        end
      end
      default: ;
    endcase
    if (w.last) begin
      r.element_done = 1'b1;
      if (held == FLT_NONE) begin
        if (ph == PH_HDR && cnt == 10'd0) r.element_ok = 1'b1;
        else if (ph == PH_PAY) held = FLT_OVERRUN;
        else held = FLT_TRUNC_HDR;
      end
    end
    r.fault = held;
    if (w.last) clear_parse();
    return r;
  endfunction

  function automatic string show(input out_t r);
    return $sformatf("kind=%0d value=%h ver=%0d len=%h end=%b done=%b ok=%b fault=%0d",
                     r.field_kind, r.field_value, r.version_kind, r.sub_length, r.sub_end,
                     r.element_done, r.element_ok, r.fault);
  endfunction

  function automatic void add_header(ref octets_t q, input logic [31:0] vendor,
                                     input logic [15:0] t, input logic [15:0] n);
    for (int i = 3; i >= 0; i--) q.push_back(vendor[8*i +: 8]);
    q.push_back(t[15:8]);
    q.push_back(t[7:0]);
    q.push_back(n[15:8]);
    q.push_back(n[7:0]);
  endfunction

  // send one element; last rides on the final byte
  task automatic send_element(input octets_t q);
    in_t w;
    foreach (q[i]) begin
      w.data_byte = q[i];
      w.last      = (i == q.size() - 1);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk); while (in_stall);
      parse_results_q.push_back(parse_step(w));
      bytes_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STRICT_MODE: cfg.strict_mode = val[0];
      CFG_ALT_LAYOUT:  cfg.alternate_layout = val[0];
      CFG_HW_TYPE:     cfg.hardware_type_code = val;
      CFG_SW_TYPE:     cfg.software_type_code = val;
      CFG_BOOT_TYPE:   cfg.bootloader_type_code = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(CFG_STRICT_MODE, {15'($urandom), c.strict_mode});
    write_reg(CFG_ALT_LAYOUT, {15'($urandom), c.alternate_layout});
    write_reg(CFG_HW_TYPE, c.hardware_type_code);
    write_reg(CFG_SW_TYPE, c.software_type_code);
    write_reg(CFG_BOOT_TYPE, c.bootloader_type_code);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_fixed_part_and_list();
    octets_t q;
    q = {8'h07};
    send_element(q);
    q = {8'hff, 8'h00, 8'h00};
    send_element(q);
    q = {8'h00, 8'hff, 8'hff, 8'h00};
    send_element(q);
    q = {8'h01, 8'h02, 8'h00};
    add_header(q, 32'h0000_0000, SwTypeReset, 16'hffff);
    q.push_back(8'hab);
    send_element(q);
    q = {8'h01, 8'h01, 8'h01, 8'h11, 8'h22, 8'h33, 8'h5a, 8'h80};
    send_element(q);
  endtask

  task automatic test_strict_and_alternate();
    octets_t q;
    cfg_t c;
    wait_idle();
    c = cfg;
    c.strict_mode = 1'b1;
    apply_config(c);
    q = {8'h01, 8'h01, 8'h00, 8'h05};
    send_element(q);
    wait_idle();
    c.alternate_layout = 1'b1;
    apply_config(c);
    q = {8'h01, 8'h01, 8'h00, 8'h00};
    send_element(q);
  endtask

  task automatic test_type_priority();
    octets_t q;
    cfg_t c;
    wait_idle();
    c = '{1'b0, 1'b0, 16'h5a5a, 16'h5a5a, 16'h5a5a};
    apply_config(c);
    q = {8'h10, 8'h20, 8'h00};
    add_header(q, 32'hffff_ffff, 16'h5a5a, 16'h0000);
    send_element(q);
  endtask

  task automatic test_register_map();
    octets_t q;
    cfg_t c;
    wait_idle();
    c = '{1'b1, 1'b1, 16'hffff, 16'h0000, 16'h8000};
    apply_config(c);
    q = {8'h80, 8'h01, 8'haa, 8'h55};
    add_header(q, 32'h8000_0001, 16'hffff, 16'h0002);
    q.push_back(8'hff);
    q.push_back(8'h00);
    send_element(q);
    wait_idle();
    // unmapped indexes must leave every register alone
    for (int i = CFG_BOOT_TYPE + 1; i < 2**CfgIndexWidth; i++) begin
      write_reg(CfgIndexWidth'(i), 16'($urandom));
    end
    cfg_valid <= 1'b0;
    send_element(q);
  endtask

  task automatic test_random_elements(input int unsigned target);
    octets_t q;
    cfg_t c;
    logic [15:0] t;
    int unsigned phase_end, n, keep;
    while (bytes_sent < target) begin
      wait_idle();
      c.strict_mode      = 1'($urandom_range(0, 1));
      c.alternate_layout = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin
          c.hardware_type_code   = 16'($urandom);
          c.software_type_code   = 16'($urandom);
          c.bootloader_type_code = 16'($urandom);
        end
        1: begin
          c.hardware_type_code   = 16'hffff;
          c.software_type_code   = 16'h0000;
          c.bootloader_type_code = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        end
        2: begin
          c.hardware_type_code   = 16'($urandom_range(0, 7));
          c.software_type_code   = $urandom_range(0, 1) ? c.hardware_type_code
                                                        : 16'($urandom_range(0, 7));
          c.bootloader_type_code = $urandom_range(0, 1) ? c.software_type_code
                                                        : 16'($urandom_range(0, 7));
        end
        default: begin
          c.hardware_type_code   = 16'($urandom_range(0, 7));
          c.software_type_code   = 16'($urandom_range(0, 7));
          c.bootloader_type_code = 16'($urandom_range(0, 7));
        end
      endcase
      apply_config(c);
      phase_end = bytes_sent + PhaseBytes;
      idle_pct = (phase_end >= target) ? 0 : 20 * $urandom_range(0, 2);
      while (bytes_sent < phase_end && bytes_sent < target) begin
        q.delete();
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        if (cfg.alternate_layout) begin
          q.push_back(8'($urandom));
          q.push_back(8'($urandom));
        end else begin
          n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
          q.push_back(8'(n));
          repeat (3 * n) q.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: t = cfg.hardware_type_code;
            1: t = cfg.software_type_code;
            2: t = cfg.bootloader_type_code;
            default: t = 16'($urandom);
          endcase
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          add_header(q, $urandom(), t, 16'(n));
          repeat (n) q.push_back(8'($urandom));
        end
        // mostly well-formed; damage a few
        case ($urandom_range(0, 19))
          0: begin
            q.delete();
            repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
          end
          1: begin
            keep = $urandom_range(1, q.size() - 1);
            while (q.size() > keep) void'(q.pop_back());
          end
          2: repeat ($urandom_range(1, 7)) q.push_back(8'($urandom));
          3: begin
            add_header(q, $urandom(), 16'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 5)) q.push_back(8'($urandom));
          end
          default: ;
        endcase
        send_element(q);
      end
    end
  endtask

  initial begin : out_stall_gen
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (burst != 0) burst--;
      else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) burst = $urandom_range(1, 4);
      out_stall <= (burst != 0);
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    string bad;
    if (rst_n && out_valid && !out_stall) begin
      if (parse_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit) $display("unexpected word: got %s", show(out_data));
      end else begin
        want = parse_results_q.pop_front();
        bad = "";
        if (out_data.field_kind !== want.field_kind) bad = {bad, " field_kind"};
        if (out_data.field_value !== want.field_value) bad = {bad, " field_value"};
        if (out_data.version_kind !== want.version_kind) bad = {bad, " version_kind"};
        if (out_data.sub_length !== want.sub_length) bad = {bad, " sub_length"};
        if (out_data.sub_end !== want.sub_end) bad = {bad, " sub_end"};
        if (out_data.element_done !== want.element_done) bad = {bad, " element_done"};
        if (out_data.element_ok !== want.element_ok) bad = {bad, " element_ok"};
        if (out_data.fault !== want.fault) bad = {bad, " fault"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= ShowLimit) begin
            $display("mismatch in%s: want %s", bad, show(want));
            $display("                got %s", show(out_data));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    cfg = '{1'b0, 1'b0, HwTypeReset, SwTypeReset, BootTypeReset};
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_fixed_part_and_list();
    test_strict_and_alternate();
    test_type_priority();
    test_register_map();
    test_random_elements(RandomBytes);
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
